### hw/rtl/rpa_pkg.sv
// Shared types and constants for the relaxed panel amalgamation block.
// No dependencies; imported by rpa_step and relaxed_panel_amalgamation.
package rpa_pkg;

  localparam int unsigned MAX_COLUMNS = 4096;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned FILL_W      = 25;
  localparam int unsigned PROD_W      = 2 * CNT_W;
  localparam int unsigned SUM_W       = PROD_W + 1;
  localparam int unsigned SLOTS       = 3;
  localparam int unsigned SLOT_CNT_W  = 2;

  // register index of panel_cap, decoded from paddr[2]
  localparam logic REG_PANEL_CAP = 1'b0;

  localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

  typedef enum logic {
    REC_COLUMN = 1'b0,
    REC_PANEL  = 1'b1
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t          kind;
    logic [IDX_W-1:0]   column;
    logic [IDX_W-1:0]   panel_id;
    logic [IDX_W-1:0]   panel_first;
    logic [CNT_W-1:0]   panel_cols;
    logic [CNT_W-1:0]   panel_width;
    logic [FILL_W-1:0]  fill;
    logic               last;
    logic               overflow;
  } record_t;

  typedef struct packed {
    record_t [SLOTS-1:0]   rec;
    logic [SLOT_CNT_W-1:0] count;
  } step_out_t;

  // saturating add of a product onto the running fill
  function automatic logic [FILL_W-1:0] fill_add(input logic [FILL_W-1:0] base,
                                                 input logic [PROD_W-1:0] add);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(add);
    return (s > SUM_W'(FILL_MAX)) ? FILL_MAX : s[FILL_W-1:0];
  endfunction

endpackage

### hw/rtl/rpa_step.sv
// Per-column panel tracking: open panel state and the records one column yields.
// Depends on rpa_pkg.
module rpa_step
  import rpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [CNT_W-1:0] parent,
  input  logic [CNT_W-1:0] col_count,
  input  logic             eom,
  input  logic [CNT_W-1:0] cap,
  output step_out_t        res
);

  logic [CNT_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [CNT_W-1:0]  prev_r, prev_nxt;
  logic [IDX_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt;
  logic [CNT_W-1:0]  width_r, width_nxt;
  logic [IDX_W-1:0]  panels_r, panels_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic              ovf, join_col, close_a, open_nz;
  logic [CNT_W-1:0]  cap_eff, max_w, size_p1, new_size, new_width;
  logic [IDX_W-1:0]  new_first, ids_after, col;
  logic [CNT_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic [FILL_W-1:0] fill_a, fill_b;
  record_t           rec_a, rec_c, rec_b;

  always_comb begin
    cap_eff   = (cap == '0) ? CNT_W'(1) : cap;
    ovf       = col_cnt_r >= CNT_W'(MAX_COLUMNS);
    col       = col_cnt_r[IDX_W-1:0];
    open_nz   = size_r != '0;
    // prev_r with the sign bit set never matches a valid column index
    join_col  = !ovf && open_nz && (prev_r == col_cnt_r) && (size_r < cap_eff);
    close_a   = !join_col && open_nz;
    max_w     = (col_count > width_r) ? col_count : width_r;
    size_p1   = size_r + CNT_W'(1);
    new_size  = join_col ? size_p1 : CNT_W'(1);
    new_width = join_col ? max_w : col_count;
    new_first = join_col ? first_r : col;
    ids_after = panels_r + IDX_W'(close_a);

    // one shared multiplier: joined panel at end, or the panel being closed
    mul_a  = join_col ? size_p1 : size_r;
    mul_b  = join_col ? max_w : width_r;
    prod   = PROD_W'(mul_a) * PROD_W'(mul_b);
    fill_a = fill_add(fill_r, prod);
    fill_b = join_col ? fill_a : fill_add(close_a ? fill_a : fill_r, PROD_W'(col_count));
  end

  always_comb begin
    rec_a             = '0;
    rec_a.kind        = REC_PANEL;
    rec_a.panel_id    = panels_r;
    rec_a.panel_first = first_r;
    rec_a.panel_cols  = size_r;
    rec_a.panel_width = width_r;
    rec_a.fill        = fill_a;
    rec_a.last        = ovf;
    rec_a.overflow    = ovf;

    rec_c          = '0;
    rec_c.kind     = REC_COLUMN;
    rec_c.column   = ovf ? '0 : col;
    rec_c.panel_id = ovf ? '0 : ids_after;
    rec_c.last     = ovf && eom && !open_nz;
    rec_c.overflow = ovf;

    rec_b             = '0;
    rec_b.kind        = REC_PANEL;
    rec_b.panel_id    = ids_after;
    rec_b.panel_first = new_first;
    rec_b.panel_cols  = new_size;
    rec_b.panel_width = new_width;
    rec_b.fill        = fill_b;
    rec_b.last        = 1'b1;
    rec_b.overflow    = 1'b0;
  end

  // record order: previous close, column, final close; on overflow, column then the open panel's close
  always_comb begin
    res.rec[0] = close_a && !ovf ? rec_a : rec_c;
    res.rec[1] = close_a && !ovf ? rec_c : (ovf ? rec_a : rec_b);
    res.rec[2] = rec_b;
    if (ovf) begin
      res.count = SLOT_CNT_W'(1) + SLOT_CNT_W'(eom && open_nz);
    end else begin
      res.count = SLOT_CNT_W'(1) + SLOT_CNT_W'(close_a) + SLOT_CNT_W'(eom);
    end
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    prev_nxt    = prev_r;
    first_nxt   = first_r;
    size_nxt    = size_r;
    width_nxt   = width_r;
    panels_nxt  = panels_r;
    fill_nxt    = fill_r;
    if (eom) begin
      col_cnt_nxt = '0;
      prev_nxt    = '1;
      first_nxt   = '0;
      size_nxt    = '0;
      width_nxt   = '0;
      panels_nxt  = '0;
      fill_nxt    = '0;
    end else if (!ovf) begin
      col_cnt_nxt = col_cnt_r + CNT_W'(1);
      prev_nxt    = parent;
      first_nxt   = new_first;
      size_nxt    = new_size;
      width_nxt   = new_width;
      panels_nxt  = ids_after;
      fill_nxt    = close_a ? fill_a : fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      prev_r    <= '1;
      first_r   <= '0;
      size_r    <= '0;
      width_r   <= '0;
      panels_r  <= '0;
      fill_r    <= '0;
    end else if (fire) begin
      col_cnt_r <= col_cnt_nxt;
      prev_r    <= prev_nxt;
      first_r   <= first_nxt;
      size_r    <= size_nxt;
      width_r   <= width_nxt;
      panels_r  <= panels_nxt;
      fill_r    <= fill_nxt;
    end
  end

endmodule

### hw/rtl/relaxed_panel_amalgamation.sv
// Relaxed panel amalgamation: stream top level, cap register and record queue.
// Depends on rpa_pkg and rpa_step.
// The first record of a column is registered and valid in the cycle after its request is taken.
// A column yields one to three records and the output sends one per cycle while
// out_tready is high; the next column is accepted only as the last record leaves.
// Reset (synchronous, rst_n low): no panel open, counters cleared, panel_cap = 1.
module relaxed_panel_amalgamation
  import rpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // parent_index[12:0], column_count[25:13], zero pad
  input  logic        in_tlast,   // end_of_matrix
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // column, panel_id, panel_first, panel_cols,
                                  // panel_width, padded_fill_total, overflow
  output logic [0:0]  out_tuser,  // record_type
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CNT_W-1:0]      cap_r;
  record_t [SLOTS-1:0]   q_r;
  logic [SLOT_CNT_W-1:0] q_cnt_r;
  logic                  in_fire, out_fire, cfg_wr;
  step_out_t             step;
  record_t               head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PANEL_CAP);
  assign prdata = (paddr[2] == REG_PANEL_CAP) ? 32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CNT_W'(1);
    end else if (cfg_wr) begin
      cap_r <= pwdata[CNT_W-1:0];
    end
  end

  assign in_tready = (q_cnt_r == '0) || ((q_cnt_r == SLOT_CNT_W'(1)) && out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  rpa_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .parent    (in_tdata[CNT_W-1:0]),
    .col_count (in_tdata[2*CNT_W-1:CNT_W]),
    .eom       (in_tlast),
    .cap       (cap_r),
    .res       (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
    end else if (in_fire) begin
      q_cnt_r <= step.count;
    end else if (out_fire) begin
      q_cnt_r <= q_cnt_r - SLOT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      q_r <= step.rec;
    end else if (out_fire) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  assign head       = q_r[0];
  assign out_tvalid = q_cnt_r != '0;
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;
  assign out_tdata  = {head.overflow, head.fill, head.panel_width, head.panel_cols,
                       head.panel_first, head.panel_id, head.column};

  a_rec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("no record after an accepted column");

  a_last_on_panel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast && !out_tdata[87]) |-> (out_tuser == REC_PANEL))
    else $error("final record of a matrix is not a panel close");

  a_panel_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == REC_PANEL)) |-> (out_tdata[48:36] != '0))
    else $error("closed panel with no columns");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && q_cnt_r != '0) |-> (q_cnt_r == SLOT_CNT_W'(1)) && out_tready)
    else $error("column accepted while records remain");

endmodule

### tb/relaxed_panel_amalgamation_tb.sv
// Self-checking bench for relaxed_panel_amalgamation: column stream in, panel records out.
// Holds its own amalgamation predictor and record checker; needs rpa_pkg and the RTL.
`timescale 1ns / 1ps

module relaxed_panel_amalgamation_tb
  import rpa_pkg::*;
();

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic signed [12:0] parent;
    logic [12:0]        count;
    logic               eom;
  } column_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // parent_index[12:0], column_count[25:13], zero pad
  logic        in_tlast = 1'b0; // end_of_matrix
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;       // column, panel_id, panel_first, panel_cols,
                                // panel_width, padded_fill_total, overflow
  logic [0:0]  out_tuser;       // record_type
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  relaxed_panel_amalgamation u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  column_req_t col_queue[$];
  record_t     expected_recs[$];
  int          err_count = 0;
  int          send_idle_pct = 6;
  int          recv_stall_pct = 69;
  int          quiet_cycles = 0;

  // predictor state
  logic [12:0]        cap_shadow;
  int unsigned        cur_col;
  logic signed [12:0] tree_par_prev;
  int unsigned        pan_start;
  int unsigned        pan_len;
  int unsigned        pan_wide;
  int unsigned        pan_count;
  longint unsigned    fill_run;
  bit                 col_excess;

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic clear_matrix_state();
    cur_col       = 0;
    tree_par_prev = -13'sd1;
    pan_start     = 0;
    pan_len       = 0;
    pan_wide      = 0;
    pan_count     = 0;
    fill_run      = 0;
    col_excess    = 1'b0;
  endtask

  function automatic record_t make_record(rec_kind_t kind, int unsigned col, int unsigned id,
                                          int unsigned first, int unsigned cols,
                                          int unsigned width, longint unsigned fill, bit lst);
    record_t r;
    r.kind        = kind;
    r.column      = IDX_W'(col);
    r.panel_id    = IDX_W'(id);
    r.panel_first = IDX_W'(first);
    r.panel_cols  = CNT_W'(cols);
    r.panel_width = CNT_W'(width);
    r.fill        = FILL_W'(fill);
    r.last        = lst;
    r.overflow    = col_excess;
    return r;
  endfunction

  task automatic close_open_panel(bit lst);
    fill_run += longint'(pan_len) * longint'(pan_wide);
    if (fill_run > FILL_MAX)
      fill_run = FILL_MAX;
    expected_recs = {expected_recs, make_record(REC_PANEL, 0, pan_count, pan_start, pan_len,
                                                pan_wide, fill_run, lst)};
    pan_count++;
    pan_len = 0;
  endtask

  task automatic amalgamate(column_req_t c);
    int unsigned eff_cap;
    bit          merge;
    eff_cap = (cap_shadow == 0) ? 1 : cap_shadow;
    if (cur_col >= MAX_COLUMNS) begin
      // excess column: flagged, joins nothing
      col_excess = 1'b1;
      expected_recs = {expected_recs, make_record(REC_COLUMN, 0, 0, 0, 0, 0, 0,
                                                  c.eom && pan_len == 0)};
      if (c.eom) begin
        if (pan_len > 0)
          close_open_panel(1'b1);
        clear_matrix_state();
      end
    end else begin
      merge = pan_len > 0 && int'(tree_par_prev) == int'(cur_col) && pan_len < eff_cap;
      if (merge) begin
        pan_len++;
        if (c.count > pan_wide)
          pan_wide = c.count;
      end else begin
        if (pan_len > 0)
          close_open_panel(1'b0);
        pan_start = cur_col;
        pan_len   = 1;
        pan_wide  = c.count;
      end
      expected_recs = {expected_recs,
                       make_record(REC_COLUMN, cur_col, pan_count, 0, 0, 0, 0, 1'b0)};
      tree_par_prev = c.parent;
      cur_col++;
      if (c.eom) begin
        close_open_panel(1'b1);
        clear_matrix_state();
      end
    end
  endtask

  task automatic cmp_field(string name, longint unsigned got, longint unsigned want);
    if (got != want)
      report_mismatch(name, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    column_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (col_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = col_queue.pop_front();
        in_tdata  <= {6'd0, nxt.count, nxt.parent};
        in_tlast  <= nxt.eom;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on each accepted column, check each accepted record
  always @(posedge clk) begin
    column_req_t seen;
    record_t     want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.parent = in_tdata[12:0];
        seen.count  = in_tdata[25:13];
        seen.eom    = in_tlast;
        amalgamate(seen);
      end
      if (out_tvalid && out_tready) begin
        if (expected_recs.size() == 0) begin
          report_mismatch("record with nothing expected, column", out_tdata[11:0], 0);
        end else begin
          want = expected_recs.pop_front();
          cmp_field("record_type", out_tuser[0], want.kind);
          cmp_field("column", out_tdata[11:0], want.column);
          cmp_field("panel_id", out_tdata[23:12], want.panel_id);
          cmp_field("panel_first", out_tdata[35:24], want.panel_first);
          cmp_field("panel_cols", out_tdata[48:36], want.panel_cols);
          cmp_field("panel_width", out_tdata[61:49], want.panel_width);
          cmp_field("padded_fill_total", out_tdata[86:62], want.fill);
          cmp_field("overflow", out_tdata[87], want.overflow);
          cmp_field("last", out_tlast, want.last);
        end
      end
    end
  end

  // watchdog: quiet cycles with no request moving on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("relaxed_panel_amalgamation_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic write_panel_cap(logic [12:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PANEL_CAP, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_shadow = val;
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[12:0] != val)
      report_mismatch("panel_cap readback", prdata[12:0], val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (col_queue.size() != 0 || in_tvalid || expected_recs.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic queue_col(int parent, int count, bit eom);
    column_req_t c;
    c.parent = 13'(parent);
    c.count  = 13'(count);
    c.eom    = eom;
    col_queue = {col_queue, c};
  endtask

  // random matrices: mostly chains so panels grow, with broken links and roots mixed in
  task automatic queue_random_matrices(int target);
    int n;
    int len;
    int r;
    int par;
    int cnt;
    n = 0;
    while (n < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70)      par = i + 1;
        else if (r < 80) par = -1;
        else             par = $urandom_range(0, 4095);
        r = $urandom_range(0, 99);
        if (r < 10)      cnt = 4096;
        else if (r < 20) cnt = 0;
        else             cnt = $urandom_range(0, 4096);
        queue_col(par, cnt, i == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    cap_shadow = 13'd1;
    clear_matrix_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // cap 1 out of reset: lone root, then a chain that cannot merge
    queue_col(-1, 0, 1'b1);
    queue_col(1, 4096, 1'b0);
    queue_col(2, 0, 1'b0);
    queue_col(-1, 5, 1'b1);
    wait_idle();

    // cap 3: chain fills a panel, then a broken link and a root
    write_panel_cap(13'd3);
    queue_col(1, 7, 1'b0);
    queue_col(2, 4096, 1'b0);
    queue_col(3, 1, 1'b0);
    queue_col(4, 2, 1'b0);
    queue_col(4095, 9, 1'b0);
    queue_col(-1, 3, 1'b1);
    wait_idle();

    // cap 0 behaves as 1
    write_panel_cap(13'd0);
    queue_col(1, 4096, 1'b0);
    queue_col(-1, 4096, 1'b1);
    wait_idle();

    send_idle_pct  = 6;
    recv_stall_pct = 69;
    write_panel_cap(13'd4096);
    queue_random_matrices(140);
    wait_idle();

    send_idle_pct  = 69;
    recv_stall_pct = 6;
    write_panel_cap(13'd2);
    queue_random_matrices(140);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_panel_cap(13'($urandom_range(3, 40)));
    queue_random_matrices(30);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("relaxed_panel_amalgamation_tb: done, clean");
    else
      $display("relaxed_panel_amalgamation_tb: done, errors");
    $finish;
  end

endmodule
